### src/pft_pkg.sv
// ============================================================================
// pft_pkg
// shared types, codes and pauli arithmetic for the pauli frame tracker
// ============================================================================
package pft_pkg;

    localparam int QUBITS_DEFAULT = 64;
    localparam int INDEX_W        = 6;
    localparam int OPCODE_W       = 3;
    localparam int MODE_W         = 4;

    typedef logic [1:0]          pauli_t;
    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [INDEX_W-1:0]  index_t;

    localparam opcode_t OP_INIT    = 3'd0;
    localparam opcode_t OP_SINGLE  = 3'd1;
    localparam opcode_t OP_CNOT    = 3'd2;
    localparam opcode_t OP_COMMUTE = 3'd3;
    localparam opcode_t OP_READ    = 3'd4;
    localparam opcode_t OP_CLEAR   = 3'd5;

    localparam pauli_t P_I = 2'd0;
    localparam pauli_t P_X = 2'd1;
    localparam pauli_t P_Y = 2'd2;
    localparam pauli_t P_Z = 2'd3;

    typedef struct packed {
        opcode_t           opcode;
        index_t            index_a;
        index_t            index_b;
        logic [MODE_W-1:0] fault_mode;
        pauli_t            init_error;
        pauli_t            compare_pauli;
        logic              last;
    } in_item_t;

    typedef struct packed {
        pauli_t pauli_a;
        pauli_t pauli_b;
        logic   commute_valid;
        logic   commutes;
        logic   bad_mode;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic ex;
        logic wa;
        logic out;
    } pft_cmd_t;

    // symplectic form: bit 1 is x, bit 0 is z
    function automatic logic [1:0] to_xz(input pauli_t p);
        logic [1:0] r;
        unique case (p)
            P_I:     r = 2'b00;
            P_X:     r = 2'b10;
            P_Y:     r = 2'b11;
            default: r = 2'b01;
        endcase
        return r;
    endfunction

    function automatic pauli_t to_code(input logic [1:0] xz);
        pauli_t r;
        unique case (xz)
            2'b00:   r = P_I;
            2'b10:   r = P_X;
            2'b11:   r = P_Y;
            default: r = P_Z;
        endcase
        return r;
    endfunction

    function automatic pauli_t pmul(input pauli_t p, input pauli_t q);
        return to_code(to_xz(p) ^ to_xz(q));
    endfunction

endpackage

### src/pft_in_if.sv
// ============================================================================
// pft_in_if
// input channel: valid, ready and one operation item
// ============================================================================
interface pft_in_if;
    import pft_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/pft_out_if.sv
// ============================================================================
// pft_out_if
// output channel: valid, ready and one result item
// ============================================================================
interface pft_out_if;
    import pft_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/pauli_frame_tracker_top.sv
// ============================================================================
// pauli_frame_tracker_top
// pauli frame with one error per qubit: init, faults, cnot, commute check
// ============================================================================
//  channel   dir   handshake        payload
//  ops       in    valid / ready    pft_pkg::in_item_t
//  results   out   valid / ready    pft_pkg::out_item_t
//
//  each item goes through read, update, second frame write, read back and
//  result load in turn; the frame memory has a single write port, and
//  a cnot writes target then control through that port
//  reset clears the frame through per-entry valid bits and clears the parity
//  a new item is taken while the previous result waits in the output register
//  a stalled output holds the sequencer in its last step
// ============================================================================
module pauli_frame_tracker_top
#(
    parameter int QUBITS = pft_pkg::QUBITS_DEFAULT
)
(
    input logic      clk,
    input logic      rst_n,
    pft_in_if.sink   ops,
    pft_out_if.source results
);
    import pft_pkg::*;

    pft_cmd_t cmd;
    logic     in_ready;
    logic     out_valid;

    pft_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ops.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (results.ready),
        .cmd       (cmd)
    );

    pft_datapath #(.QUBITS(QUBITS)) u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .item_in (ops.data),
        .result  (results.data)
    );

    assign ops.ready     = in_ready;
    assign results.valid = out_valid;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (ops.valid && ops.ready) |=> !ops.ready)
        else $error("item taken while busy");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(ops.valid && ops.ready, 6))
        else $error("result without matching item");

    a_commutes_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.data.commutes) |-> results.data.commute_valid)
        else $error("commutes set outside a run end");

    a_no_load_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out && results.valid) |-> results.ready)
        else $error("result overwritten");

endmodule

### src/pft_ctrl.sv
// ============================================================================
// pft_ctrl
// sequencer: read, update, second write, read back, hand off result
// ============================================================================
module pft_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output pft_pkg::pft_cmd_t cmd
);
    import pft_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD1  = 3'd1;
    localparam logic [2:0] S_EX   = 3'd2;
    localparam logic [2:0] S_WA   = 3'd3;
    localparam logic [2:0] S_RD2  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load = (state_reg == S_IDLE) && in_valid;
        cmd.rd   = (state_reg == S_RD1) || (state_reg == S_RD2);
        cmd.ex   = (state_reg == S_EX);
        cmd.wa   = (state_reg == S_WA);
        cmd.out  = (state_reg == S_OUT) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_RD1;
                end
            end
            S_RD1:   state_next = S_EX;
            S_EX:    state_next = S_WA;
            S_WA:    state_next = S_RD2;
            S_RD2:   state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/pft_datapath.sv
// ============================================================================
// pft_datapath
// frame memory with valid bits, pauli update logic, parity and result register
// ============================================================================
module pft_datapath
#(
    parameter int QUBITS = pft_pkg::QUBITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  pft_pkg::pft_cmd_t  cmd,
    input  pft_pkg::in_item_t  item_in,
    output pft_pkg::out_item_t result
);
    import pft_pkg::*;

    localparam int DEPTH = (QUBITS < (1 << INDEX_W)) ? QUBITS : (1 << INDEX_W);
    localparam int AW    = $clog2(DEPTH);
    localparam logic [INDEX_W:0] DEPTH_L = (INDEX_W + 1)'(DEPTH);

    pauli_t          mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;

    in_item_t  item_reg;
    pauli_t    rda_reg;
    pauli_t    rdb_reg;
    logic      va_reg;
    logic      vb_reg;
    logic      parity_reg;
    logic      cv_reg;
    logic      comm_reg;
    out_item_t result_reg;

    logic          in_a;
    logic          in_b;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    pauli_t        pa;
    pauli_t        pb;
    pauli_t        t1;
    logic [1:0]    t1_xz;
    pauli_t        c1;
    pauli_t        new_t;
    pauli_t        new_c;
    pauli_t        new_single;
    pauli_t        new_init;
    logic          bad;
    logic          clr;
    logic          anti;
    logic          is_commute;
    logic [1:0]    f_xz;
    logic [1:0]    g_xz;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    pauli_t        wr_data;

    assign in_a   = {1'b0, item_reg.index_a} < DEPTH_L;
    assign in_b   = {1'b0, item_reg.index_b} < DEPTH_L;
    assign addr_a = item_reg.index_a[AW-1:0];
    assign addr_b = item_reg.index_b[AW-1:0];

    assign pa = va_reg ? rda_reg : P_I;
    assign pb = vb_reg ? rdb_reg : P_I;

    // cnot propagation then two-qubit fault
    assign t1    = f_xz[1] ? pmul(pb, P_X) : pb;
    assign t1_xz = to_xz(t1);
    assign c1    = t1_xz[0] ? pmul(pa, P_Z) : pa;
    assign new_t = pmul(t1, item_reg.fault_mode[1:0]);
    assign new_c = pmul(c1, item_reg.fault_mode[3:2]);

    assign new_single = pmul(pa, item_reg.fault_mode[1:0]);
    assign new_init   = item_reg.fault_mode[0] ? item_reg.init_error : P_I;

    assign bad = ((item_reg.opcode == OP_INIT) && (item_reg.fault_mode > 4'd1))
              || ((item_reg.opcode == OP_SINGLE) && (item_reg.fault_mode > 4'd3));

    assign clr        = cmd.ex && (item_reg.opcode == OP_CLEAR);
    assign is_commute = cmd.ex && (item_reg.opcode == OP_COMMUTE);
    assign f_xz       = to_xz(pa);
    assign g_xz       = to_xz(item_reg.compare_pauli);
    assign anti       = (f_xz[1] & g_xz[0]) ^ (f_xz[0] & g_xz[1]);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_a;
        wr_data = new_c;
        if (cmd.ex)
        begin
            unique case (item_reg.opcode)
                OP_INIT:
                begin
                    wr_en   = in_a && !bad;
                    wr_data = new_init;
                end
                OP_SINGLE:
                begin
                    wr_en   = in_a && !bad;
                    wr_data = new_single;
                end
                OP_CNOT:
                begin
                    wr_en   = in_b;
                    wr_addr = addr_b;
                    wr_data = new_t;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        else if (cmd.wa && (item_reg.opcode == OP_CNOT))
        begin
            wr_en = in_a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item_in;
        end
        if (cmd.rd)
        begin
            rda_reg <= mem[addr_a];
            rdb_reg <= mem[addr_b];
            va_reg  <= valid_reg[addr_a] && in_a;
            vb_reg  <= valid_reg[addr_b] && in_b;
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.ex)
        begin
            cv_reg   <= is_commute && item_reg.last;
            comm_reg <= is_commute && item_reg.last && !(parity_reg ^ anti);
        end
        if (cmd.out)
        begin
            result_reg.pauli_a       <= pa;
            result_reg.pauli_b       <= pb;
            result_reg.commute_valid <= cv_reg;
            result_reg.commutes      <= comm_reg;
            result_reg.bad_mode      <= bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            parity_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end

            if (clr)
            begin
                parity_reg <= 1'b0;
            end
            else if (is_commute)
            begin
                parity_reg <= item_reg.last ? 1'b0 : (parity_reg ^ anti);
            end
        end
    end

    assign result = result_reg;

endmodule

### dv/pauli_frame_tracker_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// pauli_frame_tracker_top_tb
// self-checking bench for the pauli frame tracker: a directed pass over every
// operation, bad fault modes, same-qubit cnot, commute runs and clear, then
// random operation streams on a few hot qubits under changing idle patterns;
// each result is checked against an in-bench model of the frame and parity
// ============================================================================
module pauli_frame_tracker_top_tb;
    import pft_pkg::*;

    localparam opcode_t OP_SPARE6 = 3'd6;
    localparam opcode_t OP_SPARE7 = 3'd7;
    localparam int      N_QUBITS  = QUBITS_DEFAULT;
    localparam int      PHASE_OPS = 125;

    class frame_checker;
        pauli_t    frame_model [N_QUBITS];
        logic      parity_model;
        out_item_t pending_outcomes [$];
        int        mismatch_count;

        function new();
            wipe();
            mismatch_count = 0;
        endfunction

        function void wipe();
            foreach (frame_model[i])
                frame_model[i] = P_I;
            parity_model = 1'b0;
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction

        // phase-free pauli product is the xor of the codes
        function void note_op(in_item_t op);
            out_item_t want;
            pauli_t    ctl;
            pauli_t    tgt;
            want = '0;
            case (op.opcode)
                OP_INIT:
                    if (op.fault_mode > 1)
                        want.bad_mode = 1'b1;
                    else
                        frame_model[op.index_a] = op.fault_mode[0] ? op.init_error : P_I;
                OP_SINGLE:
                    if (op.fault_mode > 3)
                        want.bad_mode = 1'b1;
                    else
                        frame_model[op.index_a] ^= pauli_t'(op.fault_mode[1:0]);
                OP_CNOT:
                begin
                    ctl = frame_model[op.index_a];
                    tgt = frame_model[op.index_b];
                    if (ctl == P_X || ctl == P_Y)
                        tgt ^= P_X;
                    if (tgt == P_Y || tgt == P_Z)
                        ctl ^= P_Z;
                    tgt ^= pauli_t'(op.fault_mode[1:0]);
                    ctl ^= pauli_t'(op.fault_mode[3:2]);
                    frame_model[op.index_b] = tgt;
                    frame_model[op.index_a] = ctl;
                end
                OP_COMMUTE:
                begin
                    ctl = frame_model[op.index_a];
                    if (ctl != P_I && op.compare_pauli != P_I && ctl != op.compare_pauli)
                        parity_model ^= 1'b1;
                    if (op.last)
                    begin
                        want.commute_valid = 1'b1;
                        want.commutes      = ~parity_model;
                        parity_model       = 1'b0;
                    end
                end
                OP_CLEAR:
                    wipe();
                default:
                    ;
            endcase
            want.pauli_a = frame_model[op.index_a];
            want.pauli_b = frame_model[op.index_b];
            pending_outcomes = {pending_outcomes, want};
        endfunction

        task report_mismatch(input string msg);
            // quiet after the first hundred
            if (mismatch_count < 100)
                $display("%0t mismatch: %s", $time, msg);
            mismatch_count++;
        endtask

        task check_result(input out_item_t got);
            out_item_t want;
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch("result item with nothing pending");
                return;
            end
            want = pending_outcomes.pop_front();
            if (got.pauli_a !== want.pauli_a)
                report_mismatch($sformatf("pauli_a got %0d want %0d", got.pauli_a, want.pauli_a));
            if (got.pauli_b !== want.pauli_b)
                report_mismatch($sformatf("pauli_b got %0d want %0d", got.pauli_b, want.pauli_b));
            if (got.commute_valid !== want.commute_valid)
                report_mismatch($sformatf("commute_valid got %0b want %0b",
                                          got.commute_valid, want.commute_valid));
            if (got.commutes !== want.commutes)
                report_mismatch($sformatf("commutes got %0b want %0b",
                                          got.commutes, want.commutes));
            if (got.bad_mode !== want.bad_mode)
                report_mismatch($sformatf("bad_mode got %0b want %0b",
                                          got.bad_mode, want.bad_mode));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int src_idle_tab [4] = '{0, 68, 0, 27};
    int snk_stall_tab [4] = '{0, 0, 68, 27};

    frame_checker frame_chk = new();

    pft_in_if  ops_if ();
    pft_out_if res_if ();

    pauli_frame_tracker_top dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ops     (ops_if),
        .results (res_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        res_if.ready <= ($urandom_range(99) >= snk_stall_pct);

    always @(posedge clk)
        if (rst_n && res_if.valid && res_if.ready)
            frame_chk.check_result(res_if.data);

    function automatic in_item_t make_op(input opcode_t opc, input index_t a, input index_t b,
                                         input logic [3:0] mode, input pauli_t ierr,
                                         input pauli_t cmp, input logic lst);
        in_item_t op;
        op.opcode        = opc;
        op.index_a       = a;
        op.index_b       = b;
        op.fault_mode    = mode;
        op.init_error    = ierr;
        op.compare_pauli = cmp;
        op.last          = lst;
        return op;
    endfunction

    // mostly a few hot qubits so operations interact
    function automatic index_t pick_index();
        if ($urandom_range(99) < 80)
            return index_t'($urandom_range(7));
        return index_t'($urandom_range(63));
    endfunction

    function automatic in_item_t random_op();
        in_item_t op;
        int       pick;
        op = make_op(OP_READ, pick_index(), pick_index(), 4'($urandom_range(15)),
                     pauli_t'($urandom_range(3)), pauli_t'($urandom_range(3)),
                     1'($urandom_range(1)));
        pick = $urandom_range(99);
        if (pick < 18)
        begin
            op.opcode = OP_INIT;
            if ($urandom_range(9) != 0)
                op.fault_mode = 4'($urandom_range(1));
        end
        else if (pick < 40)
        begin
            op.opcode = OP_SINGLE;
            if ($urandom_range(9) != 0)
                op.fault_mode = 4'($urandom_range(3));
        end
        else if (pick < 70)
            op.opcode = OP_CNOT;
        else if (pick < 78)
            op.opcode = OP_COMMUTE;
        else if (pick < 81)
            op.opcode = OP_CLEAR;
        else if (pick < 84)
            op.opcode = ($urandom_range(1) != 0) ? OP_SPARE7 : OP_SPARE6;
        return op;
    endfunction

    task automatic send_op(input in_item_t op);
        while ($urandom_range(99) < src_idle_pct)
        begin
            ops_if.valid <= 1'b0;
            @(posedge clk);
        end
        ops_if.valid <= 1'b1;
        ops_if.data  <= op;
        @(posedge clk);
        while (!ops_if.ready)
            @(posedge clk);
        frame_chk.note_op(op);
    endtask

    task automatic send_commute_run(input int run_len);
        for (int k = 0; k < run_len; k++)
            send_op(make_op(OP_COMMUTE, pick_index(), index_t'($urandom_range(63)),
                            4'($urandom_range(15)), pauli_t'($urandom_range(3)),
                            pauli_t'($urandom_range(3)), k == run_len - 1));
    endtask

    initial
    begin
        int sent;
        int run_len;
        rst_n         = 1'b0;
        ops_if.valid  = 1'b0;
        ops_if.data   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(make_op(OP_READ,    0,  63, 0,  P_I, P_I, 0));
        send_op(make_op(OP_INIT,    0,  63, 1,  P_X, P_I, 0));
        send_op(make_op(OP_INIT,    63, 0,  1,  P_Z, P_I, 0));
        send_op(make_op(OP_INIT,    5,  0,  1,  P_Y, P_I, 0));
        send_op(make_op(OP_INIT,    5,  63, 0,  P_Z, P_I, 0));
        send_op(make_op(OP_INIT,    5,  0,  2,  P_X, P_I, 0));
        send_op(make_op(OP_INIT,    0,  5,  15, P_Z, P_Z, 1));
        send_op(make_op(OP_SINGLE,  5,  0,  3,  P_I, P_I, 0));
        send_op(make_op(OP_SINGLE,  5,  63, 0,  P_I, P_I, 0));
        send_op(make_op(OP_SINGLE,  63, 5,  1,  P_I, P_I, 0));
        send_op(make_op(OP_SINGLE,  63, 0,  4,  P_I, P_I, 0));
        send_op(make_op(OP_SINGLE,  0,  63, 15, P_Z, P_Z, 1));
        send_op(make_op(OP_CNOT,    0,  5,  0,  P_I, P_I, 0));
        send_op(make_op(OP_CNOT,    63, 0,  15, P_I, P_I, 0));
        send_op(make_op(OP_CNOT,    5,  5,  6,  P_I, P_I, 0));
        send_op(make_op(OP_COMMUTE, 0,  63, 0,  P_I, P_Z, 0));
        send_op(make_op(OP_COMMUTE, 63, 0,  0,  P_I, P_X, 0));
        send_op(make_op(OP_COMMUTE, 5,  0,  0,  P_I, P_Z, 1));
        send_op(make_op(OP_COMMUTE, 0,  5,  0,  P_I, P_X, 0));
        send_op(make_op(OP_CLEAR,   0,  63, 0,  P_I, P_I, 0));
        send_op(make_op(OP_COMMUTE, 0,  63, 0,  P_I, P_Z, 1));
        send_op(make_op(OP_SPARE6,  63, 0,  15, P_Z, P_Z, 1));
        send_op(make_op(OP_SPARE7,  42, 21, 9,  P_Y, P_Z, 1));
        send_op(make_op(OP_READ,    63, 0,  0,  P_I, P_I, 0));

        sent = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            src_idle_pct  = src_idle_tab[phase];
            snk_stall_pct = snk_stall_tab[phase];
            while (sent < (phase + 1) * PHASE_OPS)
            begin
                if ($urandom_range(99) < 20)
                begin
                    run_len = $urandom_range(1, 6);
                    send_commute_run(run_len);
                    sent += run_len;
                end
                else
                begin
                    send_op(random_op());
                    sent++;
                end
            end
        end

        ops_if.valid <= 1'b0;
        while (frame_chk.pending() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (frame_chk.mismatch_count == 0)
            $display("PASS pauli_frame_tracker_top");
        else
            $display("FAIL pauli_frame_tracker_top");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("FAIL pauli_frame_tracker_top");
        $finish;
    end

endmodule
